// File: sv/hbd_pkg.sv
// ----------------------------------------------------------------------------
// Halfband decimator package
// Widths, register map and command types shared by the decimator modules.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int BRANCH_TAPS   = 8;
  localparam int CENTRE_ODD    = 1;
  localparam int SAMPLE_BITS   = 24;

  localparam int NUM_TAP_REGS  = 8;
  localparam int TAP_BITS      = 18;
  localparam int FRAC_BITS     = 17;
  localparam int EXTRA_DELAY   = 1 - CENTRE_ODD;
  localparam int HIST_LEN      = BRANCH_TAPS + EXTRA_DELAY;
  localparam int DELAY_DEPTH   = BRANCH_TAPS / 2;

  localparam int REG_IDX_W     = $clog2(NUM_TAP_REGS);
  localparam int PADDR_W       = REG_IDX_W + 2;
  localparam int PDATA_W       = 32;

  localparam int TAP_IDX_W     = (BRANCH_TAPS > 1) ? $clog2(BRANCH_TAPS) : 1;
  localparam int HIST_IDX_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int CNT_W         = $clog2(BRANCH_TAPS + 1);

  localparam int PROD_W        = SAMPLE_BITS + TAP_BITS;
  localparam int ACC_W         = PROD_W + 4;
  localparam int RES_W         = ACC_W - FRAC_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [TAP_BITS-1:0]    tap_t;
  typedef tap_t                          tap_arr_t [NUM_TAP_REGS];

  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic                 acc_en;
    logic                 out_load;
    logic [TAP_IDX_W-1:0] tap_idx;
  } dp_cmd_t;

endpackage

// File: sv/hbd_cfg.sv
// ----------------------------------------------------------------------------
// Halfband decimator coefficient registers
// APB-style register file holding the branch coefficients.
// ----------------------------------------------------------------------------
module hbd_cfg import hbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output tap_arr_t           taps_o
);

  tap_arr_t              tap_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  wr_en;
  tap_t                  rd_tap;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign rd_tap  = tap_q[reg_idx];
  assign prdata  = {{(PDATA_W-TAP_BITS){rd_tap[TAP_BITS-1]}}, rd_tap};
  assign taps_o  = tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TAP_REGS; i++) begin
        tap_q[i] <= '0;
      end
    end else if (wr_en) begin
      tap_q[reg_idx] <= pwdata[TAP_BITS-1:0];
    end
  end

endmodule

// File: sv/hbd_ctrl.sv
// ----------------------------------------------------------------------------
// Halfband decimator controller
// Sequences load, multiply-accumulate and output write for each transaction.
// ----------------------------------------------------------------------------
module hbd_ctrl import hbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o.load     = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.acc_en   = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.tap_idx  = cnt_q[TAP_IDX_W-1:0];
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.mul_en = (cnt_q < CNT_W'(BRANCH_TAPS));
        cmd_o.acc_en = (cnt_q != '0);
        if (cnt_q == CNT_W'(BRANCH_TAPS)) begin
          state_d = S_WRITE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_WRITE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/hbd_datapath.sv
// ----------------------------------------------------------------------------
// Halfband decimator datapath
// Branch histories, one shared multiplier, accumulator, rounding and clamp.
// ----------------------------------------------------------------------------
module hbd_datapath import hbd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  input  tap_arr_t taps_i,
  input  sample_t  sample_first_i,
  input  sample_t  sample_second_i,
  output sample_t  sample_out_o
);

  sample_t                  hist_q [HIST_LEN];
  sample_t                  dly_q  [DELAY_DEPTH];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  sample_t                  out_q;

  sample_t                  to_filter;
  sample_t                  to_delay;
  sample_t                  delayed;
  logic [HIST_IDX_W-1:0]    hist_idx;
  sample_t                  hist_sel;
  tap_t                     tap_sel;
  logic signed [ACC_W-1:0]  acc_init;
  logic signed [RES_W-1:0]  res;
  logic                     ovf;
  sample_t                  sat;

  assign to_filter = (CENTRE_ODD != 0) ? sample_first_i  : sample_second_i;
  assign to_delay  = (CENTRE_ODD != 0) ? sample_second_i : sample_first_i;
  assign delayed   = dly_q[DELAY_DEPTH-1];

  assign hist_idx  = HIST_IDX_W'(cmd_i.tap_idx) + HIST_IDX_W'(EXTRA_DELAY);
  assign hist_sel  = hist_q[hist_idx];
  assign tap_sel   = taps_i[REG_IDX_W'(cmd_i.tap_idx)];

  assign acc_init  = (ACC_W'(delayed) <<< (FRAC_BITS - 1))
                   + ACC_W'(signed'({1'b0, 1'b1, {(FRAC_BITS-1){1'b0}}}));

  assign res = acc_q[ACC_W-1:FRAC_BITS];
  assign ovf = (res[RES_W-1:SAMPLE_BITS-1] != {(RES_W-SAMPLE_BITS+1){1'b0}})
            && (res[RES_W-1:SAMPLE_BITS-1] != {(RES_W-SAMPLE_BITS+1){1'b1}});

  always_comb begin
    if (ovf) begin
      sat = res[RES_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      sat = res[SAMPLE_BITS-1:0];
    end
  end

  assign sample_out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        dly_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      hist_q[0] <= to_filter;
      for (int i = 1; i < HIST_LEN; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      dly_q[0] <= to_delay;
      for (int i = 1; i < DELAY_DEPTH; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= hist_sel * tap_sel;
    end
    if (cmd_i.load) begin
      acc_q <= acc_init;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.out_load) begin
      out_q <= sat;
    end
  end

endmodule

// File: sv/halfband_decimator_by_two_top.sv
// ----------------------------------------------------------------------------
// Halfband decimator by two
// Polyphase halfband decimator: one output sample per input sample pair.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------------
//  input    | in_valid_i   | in_stall_o   | sample_first_i, sample_second_i
//  output   | out_valid_o  | out_stall_i  | sample_out_o
//  config   | psel/penable | pready (=1)  | paddr, pwdata, prdata
//
//  A transaction steps the single shared multiplier once per branch tap,
//  with load, drain and write steps around it.
//  The output register holds a finished sample while the next pair is taken.
//  A stalled output holds the write step until the register frees up.
//  Reset clears coefficients, both branch histories and all control state.
// ----------------------------------------------------------------------------
module halfband_decimator_by_two_top import hbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sample_t            sample_first_i,
  input  sample_t            sample_second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sample_t            sample_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  tap_arr_t taps;
  dp_cmd_t  cmd;

  hbd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .taps_o  (taps)
  );

  hbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  hbd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .taps_i          (taps),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .sample_out_o    (sample_out_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Halfband decimator by two testbench
// Offers sample pairs in bursts against a stalling receiver, predicts each
// decimated sample from a local model of both branches and the coefficient
// set, and compares every output transaction in order. Coefficients are set
// over the register port between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
  import hbd_pkg::*;

  localparam int     DLY_LEN       = DELAY_DEPTH + 1;
  localparam longint SAMPLE_MAX    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;
  localparam longint TAP_MAX       = (longint'(1) <<< (TAP_BITS - 1)) - 1;
  localparam longint TAP_MIN       = -TAP_MAX - 1;
  localparam longint HALF_Q        = longint'(1) <<< (FRAC_BITS - 1);
  localparam int     ITEM_CYCLES   = BRANCH_TAPS + 3;
  localparam int     SETTLE_CYCLES = 2 * ITEM_CYCLES;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     QUIET_LIMIT   = 5000;
  localparam int     MAX_REPORTS   = 10;
  localparam int     NUM_PHASES    = 12;
  localparam int     PHASE_ITEMS   = 120;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TAP_0, REG_TAP_1, REG_TAP_2, REG_TAP_3,
    REG_TAP_4, REG_TAP_5, REG_TAP_6, REG_TAP_7
  } tap_reg_e;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  sample_t            sample_first_i;
  sample_t            sample_second_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sample_t            sample_out_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tap_t    coef      [NUM_TAP_REGS];
  sample_t fir_hist  [HIST_LEN];
  int      fir_wp;
  sample_t half_line [DLY_LEN];
  int      half_wp;
  sample_t expected_out_q [$];
  sample_t expected_now;
  int      mismatches   = 0;
  int      results_seen = 0;

  int       burst_left = 0;
  bit       gaps_on    = 1'b0;
  int       hold_seq   = 0;
  int       hold_seen  = 0;
  int       hold_left  = 0;
  int       run_left   = 0;
  rx_mode_e rx_mode    = RX_FREE;

  halfband_decimator_by_two_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sample_t decimate_pair(input sample_t first, input sample_t second);
    longint  acc;
    longint  total;
    sample_t fir_in;
    sample_t dly_in;
    int      idx;
    int      k;
    fir_in = (CENTRE_ODD != 0) ? first : second;
    dly_in = (CENTRE_ODD != 0) ? second : first;
    fir_hist[fir_wp] = fir_in;
    idx = (fir_wp + HIST_LEN - EXTRA_DELAY) % HIST_LEN;
    acc = 0;
    for (k = 0; k < BRANCH_TAPS; k++) begin
      acc += longint'(coef[k]) * longint'(fir_hist[idx]);
      idx = (idx == 0) ? HIST_LEN - 1 : idx - 1;
    end
    half_line[half_wp] = dly_in;
    acc += longint'(half_line[(half_wp + 1) % DLY_LEN]) * HALF_Q;
    total = (acc + HALF_Q) >>> FRAC_BITS;
    if (total > SAMPLE_MAX) begin
      total = SAMPLE_MAX;
    end else if (total < SAMPLE_MIN) begin
      total = SAMPLE_MIN;
    end
    fir_wp  = (fir_wp + 1) % HIST_LEN;
    half_wp = (half_wp + 1) % DLY_LEN;
    return sample_t'(total);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
      3:       return '0;
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic tap_t rand_tap();
    case ($urandom_range(0, 7))
      0:       return tap_t'(TAP_MAX);
      1:       return tap_t'(TAP_MIN);
      2:       return '0;
      3:       return tap_t'(int'($urandom_range(0, 2048)) - 1024);
      default: return tap_t'($urandom());
    endcase
  endfunction

  task automatic note_mismatch(input string what, input longint exp_val, input longint act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
    end
  endtask

  task automatic apb_transfer(input tap_reg_e reg_sel, input logic wr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_tap(input tap_reg_e reg_sel, input tap_t value);
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] ignored;
    word = $urandom();
    word[TAP_BITS-1:0] = value;
    apb_transfer(reg_sel, 1'b1, word, ignored);
    coef[reg_sel] = value;
  endtask

  task automatic read_back_taps();
    logic [PDATA_W-1:0] word;
    int                 k;
    for (k = 0; k < NUM_TAP_REGS; k++) begin
      apb_transfer(tap_reg_e'(k), 1'b0, '0, word);
      if (word[TAP_BITS-1:0] !== coef[k]) begin
        note_mismatch($sformatf("tap_%0d read", k), coef[k], tap_t'(word[TAP_BITS-1:0]));
      end
    end
  endtask

  task automatic send_pair(input sample_t first, input sample_t second);
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i      <= 1'b1;
    sample_first_i  <= first;
    sample_second_i <= second;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_out_q.insert(expected_out_q.size(), decimate_pair(first, second));
  endtask

  task automatic drain_results(input bit settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_out_q.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    gaps_on = 1'b0;
    send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    send_pair(sample_t'(1), sample_t'(-1));
    send_pair(sample_t'(-1), sample_t'(1));
    send_pair(sample_t'(0), sample_t'(SAMPLE_MAX));
  endtask

  task automatic test_tap_impulse();
    tap_t shape [NUM_TAP_REGS] = '{tap_t'(131071), tap_t'(-131072), tap_t'(65536),
                                   tap_t'(-1), tap_t'(1), tap_t'(-65536),
                                   tap_t'(12345), tap_t'(-54321)};
    int   k;
    drain_results(1'b1);
    for (k = 0; k < NUM_TAP_REGS; k++) write_tap(tap_reg_e'(k), shape[k]);
    send_pair(sample_t'(SAMPLE_MAX), '0);
    repeat (BRANCH_TAPS) send_pair('0, '0);
  endtask

  task automatic test_saturation();
    int k;
    drain_results(1'b1);
    for (k = 0; k < NUM_TAP_REGS; k++) write_tap(tap_reg_e'(k), tap_t'(TAP_MAX));
    repeat (2) send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
    repeat (2) send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
    drain_results(1'b1);
    for (k = 0; k < NUM_TAP_REGS; k++) write_tap(tap_reg_e'(k), tap_t'(TAP_MIN));
    send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN));
    send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
    send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
  endtask

  task automatic test_tap_settings();
    tap_t setting;
    int   p;
    int   k;
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results(1'b1);
      for (k = 0; k < NUM_TAP_REGS; k++) begin
        case (p)
          0:       setting = tap_t'(TAP_MAX);
          1:       setting = tap_t'(TAP_MIN);
          2:       setting = '0;
          default: setting = rand_tap();
        endcase
        write_tap(tap_reg_e'(k), setting);
      end
      read_back_taps();
      gaps_on = (p % 3 != 2);
      repeat (PHASE_ITEMS) send_pair(rand_sample(), rand_sample());
    end
  endtask

  task automatic test_output_holdoff();
    gaps_on = 1'b0;
    hold_seq <= hold_seq + 1;
    repeat (80) send_pair(rand_sample(), rand_sample());
  endtask

  task automatic test_drain_pause();
    gaps_on = 1'b1;
    repeat (40) send_pair(rand_sample(), rand_sample());
    drain_results(1'b0);
    repeat (40) send_pair(rand_sample(), rand_sample());
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (run_left == 0) begin
        rx_mode  <= rx_mode_e'($urandom_range(0, 3));
        run_left <= $urandom_range(16, 160);
      end else begin
        run_left <= run_left - 1;
      end
      case (rx_mode)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall_i <= ($urandom_range(0, 1) == 1);
        default:  out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected output transaction %0d: got %0d", results_seen, sample_out_o);
        end
      end else begin
        expected_now = expected_out_q.pop_front();
        if (sample_out_o !== expected_now) begin
          note_mismatch($sformatf("sample_out, transaction %0d", results_seen),
                        expected_now, sample_out_o);
        end
      end
      results_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int k;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_first_i  = '0;
    sample_second_i = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    for (k = 0; k < NUM_TAP_REGS; k++) coef[k] = '0;
    for (k = 0; k < HIST_LEN; k++) fir_hist[k] = '0;
    for (k = 0; k < DLY_LEN; k++) half_line[k] = '0;
    fir_wp  = 0;
    half_wp = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_tap_impulse();
    test_saturation();
    test_tap_settings();
    test_output_holdoff();
    test_drain_pause();

    drain_results(1'b1);
    if (mismatches == 0 && expected_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/hbd_pkg.sv
sv/hbd_cfg.sv
sv/hbd_ctrl.sv
sv/hbd_datapath.sv
sv/halfband_decimator_by_two_top.sv
tb/tb_top.sv
